@@ rtl/krt_pkg.sv @@
`timescale 1ns / 1ps

package krt_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int FUNC_W      = 3;
    localparam int KEY_W       = 32;
    localparam int PRICE_W     = 24;
    localparam int AMT_W       = 16;
    localparam int POS_W       = 6;
    localparam int STAT_W      = 2;
    localparam int COUNT_OUT_W = 7;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 80;

    localparam logic [FUNC_W-1:0] OP_ADD    = 3'd0;
    localparam logic [FUNC_W-1:0] OP_FIND   = 3'd1;
    localparam logic [FUNC_W-1:0] OP_UPDATE = 3'd2;
    localparam logic [FUNC_W-1:0] OP_DELETE = 3'd3;
    localparam logic [FUNC_W-1:0] OP_READ   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] price;
        logic [AMT_W-1:0]   amount;
    } record_t;

    typedef struct packed {
        logic load;
        logic upd;
        logic shift;
    } cell_ctrl_t;

endpackage

@@ rtl/krt_cell.sv @@
`timescale 1ns / 1ps

module krt_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                      aclk,
    input  krt_pkg::cell_ctrl_t       ctrl,
    input  krt_pkg::record_t          wr_data,
    input  krt_pkg::record_t          nbr_data,
    input  logic [krt_pkg::KEY_W-1:0] search_key,
    input  logic [CNT_W-1:0]          count,
    output krt_pkg::record_t          rec,
    output logic                      match
);

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

    krt_pkg::record_t rec_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rec_reg <= wr_data;
        end else if (ctrl.upd) begin
            rec_reg.amount <= wr_data.amount;
        end else if (ctrl.shift) begin
            rec_reg <= nbr_data;
        end
    end

    assign rec   = rec_reg;
    assign match = (rec_reg.key == search_key) && (MY_POS < count);

endmodule

@@ rtl/krt_first_match.sv @@
`timescale 1ns / 1ps

module krt_first_match #(
    parameter int N = 64
) (
    input  logic [N-1:0] match,
    output logic [N-1:0] first,
    output logic [N-1:0] from_first,
    output logic         any
);

    localparam int LVL = $clog2(N);

    logic [LVL:0][N-1:0] pre;
    logic [N-1:0]        excl;

    assign pre[0] = match;

    // log-depth prefix or over the match row
    for (genvar l = 0; l < LVL; l++) begin : g_lvl
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= (1 << l)) begin : g_or
                assign pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
            end else begin : g_pass
                assign pre[l+1][i] = pre[l][i];
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_excl
        if (i == 0) begin : g_zero
            assign excl[i] = 1'b0;
        end else begin : g_prev
            assign excl[i] = pre[LVL][i-1];
        end
    end

    assign first      = match & ~excl;
    assign from_first = pre[LVL];
    assign any        = pre[LVL][N-1];

endmodule

@@ rtl/keyed_record_table.sv @@
`timescale 1ns / 1ps

// Insertion-ordered table of up to DEPTH records (key, price in cents, quantity) held in a
// row of cells. Each command is registered when taken, its key is compared against every
// cell at once in the compare state, and in the resolve state the first match is
// resolved, the row is written (append, quantity update, or a one-place shift down for
// delete) and the result is registered. A new command is accepted in the cycle after the
// previous result is loaded, so the table works on one command at a time; a stalled
// result holds the command behind it in its resolve state. Commands go in on s_axis with
// the operation in tuser; results come out on m_axis with the status in tuser.
module keyed_record_table #(
    parameter int DEPTH = krt_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // item_key[31:0], price_cents[55:32], amount[71:56], position[77:72], zero fill
    input  logic [krt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // func[2:0]
    input  logic [krt_pkg::FUNC_W-1:0]        s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // found_key[31:0], found_price[55:32], found_amount[71:56], entry_count[78:72], zero fill
    output logic [krt_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // status[1:0]
    output logic [krt_pkg::STAT_W-1:0]        m_axis_tuser
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > krt_pkg::POS_W) ? CNT_W : krt_pkg::POS_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_RES  = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [krt_pkg::FUNC_W-1:0] op_func_reg;
    krt_pkg::record_t           op_rec_reg;
    logic [krt_pkg::POS_W-1:0]  op_pos_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [DEPTH-1:0]           match_reg;

    logic                       m_valid_reg;
    logic [krt_pkg::STAT_W-1:0] m_status_reg;
    krt_pkg::record_t           m_rec_reg;
    logic [krt_pkg::COUNT_OUT_W-1:0] m_count_reg;

    krt_pkg::record_t    cell_rec   [DEPTH];
    krt_pkg::cell_ctrl_t cell_ctrl  [DEPTH];
    logic [DEPTH-1:0]    cell_match;
    logic [DEPTH-1:0]    first;
    logic [DEPTH-1:0]    from_first;
    logic [DEPTH-1:0]    rd_hit;
    logic                any_match;

    krt_pkg::record_t           sel_rec, rd_rec, res_rec, wr_data;
    logic [krt_pkg::STAT_W-1:0] res_status;
    logic                       do_add, do_upd, do_del;
    logic                       fire;
    logic [CMP_W-1:0]           pos_ext, cnt_ext;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign fire = (state_reg == S_RES) && (!m_valid_reg || m_axis_tready);

    assign wr_data = op_rec_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        krt_pkg::record_t nbr;

        if (i == DEPTH - 1) begin : g_last
            assign nbr = cell_rec[i];
        end else begin : g_mid
            assign nbr = cell_rec[i+1];
        end

        if (i < (1 << krt_pkg::POS_W)) begin : g_rd
            assign rd_hit[i] = (op_pos_reg == krt_pkg::POS_W'(i));
        end else begin : g_nord
            assign rd_hit[i] = 1'b0;
        end

        assign cell_ctrl[i].load  = fire && do_add && (count_reg == CNT_W'(i));
        assign cell_ctrl[i].upd   = fire && do_upd && first[i];
        assign cell_ctrl[i].shift = fire && do_del && from_first[i];

        krt_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[i]),
            .wr_data    (wr_data),
            .nbr_data   (nbr),
            .search_key (op_rec_reg.key),
            .count      (count_reg),
            .rec        (cell_rec[i]),
            .match      (cell_match[i])
        );
    end

    krt_first_match #(
        .N (DEPTH)
    ) u_first (
        .match      (match_reg),
        .first      (first),
        .from_first (from_first),
        .any        (any_match)
    );

    // one-hot and-or selects
    always_comb begin
        sel_rec = '0;
        rd_rec  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first[i]) begin
                sel_rec = sel_rec | cell_rec[i];
            end
            if (rd_hit[i]) begin
                rd_rec = rd_rec | cell_rec[i];
            end
        end
    end

    assign pos_ext = CMP_W'(op_pos_reg);
    assign cnt_ext = CMP_W'(count_reg);

    always_comb begin
        res_status = krt_pkg::ST_OK;
        res_rec    = '0;
        count_next = count_reg;
        do_add     = 1'b0;
        do_upd     = 1'b0;
        do_del     = 1'b0;
        case (op_func_reg)
            krt_pkg::OP_ADD: begin
                if (count_reg != FULL_COUNT) begin
                    do_add     = 1'b1;
                    res_rec    = op_rec_reg;
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    res_status = krt_pkg::ST_FULL;
                end
            end
            krt_pkg::OP_FIND, krt_pkg::OP_UPDATE, krt_pkg::OP_DELETE: begin
                if (any_match) begin
                    res_rec = sel_rec;
                    if (op_func_reg == krt_pkg::OP_UPDATE) begin
                        do_upd         = 1'b1;
                        res_rec.amount = op_rec_reg.amount;
                    end
                    if (op_func_reg == krt_pkg::OP_DELETE) begin
                        do_del     = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end else begin
                    res_status = krt_pkg::ST_MISSING;
                end
            end
            krt_pkg::OP_READ: begin
                if (pos_ext < cnt_ext) begin
                    res_rec = rd_rec;
                end else begin
                    res_status = krt_pkg::ST_RANGE;
                end
            end
            default: begin
                res_status = krt_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_RES;
            end
            S_RES: begin
                if (fire) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            op_func_reg       <= s_axis_tuser;
            op_rec_reg.key    <= s_axis_tdata[31:0];
            op_rec_reg.price  <= s_axis_tdata[55:32];
            op_rec_reg.amount <= s_axis_tdata[71:56];
            op_pos_reg        <= s_axis_tdata[77:72];
        end
        if (state_reg == S_CMP) begin
            match_reg <= cell_match;
        end
        if (fire) begin
            m_status_reg <= res_status;
            m_rec_reg    <= res_rec;
            m_count_reg  <= krt_pkg::COUNT_OUT_W'(count_next);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {1'b0, m_count_reg, m_rec_reg.amount, m_rec_reg.price, m_rec_reg.key};

endmodule
